>>> sv/npws_pkg.sv
package npws_pkg;

    // Field widths of the record, the result and the configuration registers.
    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int INDEX_W = 20;
    localparam int SCALE_W = 17;
    localparam int WIN_W   = 30;
    localparam int DIST_W  = 63;
    localparam int CFG_W   = 63;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LON_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_WINDOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_SQ = 3'd4;

    // Register reset values.
    localparam logic [LAT_W-1:0]   TARGET_LAT_RST  = '0;
    localparam logic [LON_W-1:0]   TARGET_LON_RST  = '0;
    localparam logic [SCALE_W-1:0] LON_SCALE_RST   = 17'd65536;
    localparam logic [WIN_W-1:0]   LAT_WINDOW_RST  = 30'd4194304;
    localparam logic [DIST_W-1:0]  MAX_DIST_SQ_RST = 63'd703687441777;

    // Saturation limits.
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam int SCALED_W = 34;
    localparam logic [SCALED_W-1:0] SQ_LIMIT = 34'd3037000499;
    localparam logic [49:0] ROUND_HALF = 50'd32768;

    // Sequencer steps.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_ACCEPT = 3'd0;
    localparam logic [STEP_W-1:0] S_SCALE  = 3'd1;
    localparam logic [STEP_W-1:0] S_DLAT   = 3'd2;
    localparam logic [STEP_W-1:0] S_DSCL   = 3'd3;
    localparam logic [STEP_W-1:0] S_SUM    = 3'd4;
    localparam logic [STEP_W-1:0] S_EMIT   = 3'd5;

    // Multiplier operand selects.
    localparam logic [1:0] MUL_LON  = 2'd0;
    localparam logic [1:0] MUL_DLAT = 2'd1;
    localparam logic [1:0] MUL_SCL  = 2'd2;

    // Jump conditions.
    localparam logic [1:0] C_NEVER       = 2'd0;
    localparam logic [1:0] C_NO_INPUT    = 2'd1;
    localparam logic [1:0] C_SKIP        = 2'd2;
    localparam logic [1:0] C_OUT_BLOCKED = 2'd3;

    typedef struct packed {
        logic [1:0]        mul_sel;
        logic              ld_prod;
        logic              ld_scaled;
        logic              ld_acc;
        logic              win_chk;
        logic              upd_best;
        logic              emit_en;
        logic [1:0]        cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } ctrl_t;

    // Control store: one word per step.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{mul_sel: MUL_LON, ld_prod: 1'b0, ld_scaled: 1'b0, ld_acc: 1'b0,
              win_chk: 1'b0, upd_best: 1'b0, emit_en: 1'b0, cond: C_NEVER,
              tgt_true: S_ACCEPT, tgt_false: S_ACCEPT};
        case (step)
            S_ACCEPT:
            begin
                w.cond      = C_NO_INPUT;
                w.tgt_true  = S_ACCEPT;
                w.tgt_false = S_SCALE;
            end
            S_SCALE:
            begin
                w.mul_sel   = MUL_LON;
                w.ld_prod   = 1'b1;
                w.win_chk   = 1'b1;
                w.cond      = C_SKIP;
                w.tgt_true  = S_EMIT;
                w.tgt_false = S_DLAT;
            end
            S_DLAT:
            begin
                w.mul_sel   = MUL_DLAT;
                w.ld_prod   = 1'b1;
                w.ld_scaled = 1'b1;
                w.tgt_false = S_DSCL;
            end
            S_DSCL:
            begin
                w.mul_sel   = MUL_SCL;
                w.ld_prod   = 1'b1;
                w.ld_acc    = 1'b1;
                w.tgt_false = S_SUM;
            end
            S_SUM:
            begin
                w.upd_best  = 1'b1;
                w.tgt_false = S_EMIT;
            end
            S_EMIT:
            begin
                w.emit_en   = 1'b1;
                w.cond      = C_OUT_BLOCKED;
                w.tgt_true  = S_EMIT;
                w.tgt_false = S_ACCEPT;
            end
            default:
            begin
                w.tgt_false = S_ACCEPT;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/npws_in_if.sv
interface npws_in_if;
    logic                            valid;
    logic                            ready;
    logic                            first;
    logic                            last;
    logic [npws_pkg::LAT_W-1:0]      rec_lat;
    logic [npws_pkg::LON_W-1:0]      rec_lon;
    logic [npws_pkg::INDEX_W-1:0]    rec_index;

    modport source (output valid, first, last, rec_lat, rec_lon, rec_index, input ready);
    modport sink (input valid, first, last, rec_lat, rec_lon, rec_index, output ready);
endinterface

>>> sv/npws_out_if.sv
interface npws_out_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [npws_pkg::INDEX_W-1:0]    best_index;
    logic [npws_pkg::DIST_W-1:0]     best_dist;

    modport source (output valid, found, best_index, best_dist, input ready);
    modport sink (input valid, found, best_index, best_dist, output ready);
endinterface

>>> sv/nearest_point_window_scan_unit.sv
// Nearest-point scan over a latitude-sorted table. Records stream in on in_ch;
// the unit keeps the record with the smallest squared distance
// dLat^2 + (dLon * lon_scale / 2^16)^2 to the target and sends one result on out_ch
// when the record marked last has been processed. A record that falls inside
// the latitude window runs the steps ACCEPT, SCALE, DLAT, DSCL, SUM and EMIT;
// a record outside it, or after the window has been passed, goes from SCALE
// to EMIT. A new record is taken only in ACCEPT. The steps come from the step
// program of the sequencer, which runs the three products of a record one
// after another through a single shared 33 x 32 multiplier. On a last record
// the unit waits in its final step while an earlier result is still held in
// the output register. Configuration registers are written through cfg_we /
// cfg_index / cfg_data and must only change while the unit is idle.
module nearest_point_window_scan_unit #(
    parameter int INDEX_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [npws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [npws_pkg::CFG_W-1:0]          cfg_data,
    npws_in_if.sink                             in_ch,
    npws_out_if.source                          out_ch
);

    localparam int IW    = npws_pkg::INDEX_W;
    localparam int IDX_W = (INDEX_BITS < IW) ? INDEX_BITS : IW;

    // Configuration registers.
    logic [npws_pkg::LAT_W-1:0]   target_lat_reg;
    logic [npws_pkg::LON_W-1:0]   target_lon_reg;
    logic [npws_pkg::SCALE_W-1:0] lon_scale_reg;
    logic [npws_pkg::WIN_W-1:0]   lat_window_reg;
    logic [npws_pkg::DIST_W-1:0]  max_dist_sq_reg;

    // Sequencer.
    logic [npws_pkg::STEP_W-1:0]  step_reg;
    logic [npws_pkg::STEP_W-1:0]  step_next;
    npws_pkg::ctrl_t              uc;
    logic                         cond_hit;

    // Search state.
    logic [npws_pkg::DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic                         window_passed_reg;

    // Datapath registers.
    logic                         last_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [31:0]                  dlat_reg;
    logic [31:0]                  dlat_mag_reg;
    logic [32:0]                  dlon_mag_reg;
    logic [64:0]                  prod_reg;
    logic [31:0]                  scaled_reg;
    logic                         scaled_sat_reg;
    logic [npws_pkg::DIST_W-1:0]  acc_reg;

    // Output register.
    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic [IW-1:0]                out_index_reg;
    logic [npws_pkg::DIST_W-1:0]  out_dist_reg;

    logic                         in_xfer;
    logic                         out_blocked;
    logic                         emit;
    logic                         restart_in;
    logic                         above_win;
    logic                         below_win;
    logic                         skip;
    logic [31:0]                  dlat_w;
    logic [31:0]                  dlat_mag_w;
    logic [32:0]                  dlon_w;
    logic [32:0]                  dlon_mag_w;
    logic [32:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [64:0]                  mul_p;
    logic [49:0]                  rnd_w;
    logic [npws_pkg::SCALED_W-1:0] scaled_w;
    logic [npws_pkg::DIST_W-1:0]  sq2_w;
    logic [63:0]                  sum_w;
    logic [npws_pkg::DIST_W-1:0]  dist_w;
    logic                         found_w;

    assign uc = npws_pkg::ucode(step_reg);

    assign in_ch.ready = (step_reg == npws_pkg::S_ACCEPT);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign restart_in  = in_xfer && in_ch.first;
    assign out_blocked = last_reg && out_valid_reg && !out_ch.ready;
    assign emit        = uc.emit_en && last_reg && !out_blocked;

    // Differences to the target, taken as magnitudes at the transfer.
    assign dlat_w     = {in_ch.rec_lat[npws_pkg::LAT_W-1], in_ch.rec_lat}
                      - {target_lat_reg[npws_pkg::LAT_W-1], target_lat_reg};
    assign dlat_mag_w = dlat_w[31] ? (32'd0 - dlat_w) : dlat_w;
    assign dlon_w     = {in_ch.rec_lon[npws_pkg::LON_W-1], in_ch.rec_lon}
                      - {target_lon_reg[npws_pkg::LON_W-1], target_lon_reg};
    assign dlon_mag_w = dlon_w[32] ? (33'd0 - dlon_w) : dlon_w;

    // Both window edges count as inside.
    assign above_win = $signed({dlat_reg[31], dlat_reg}) > $signed({3'b000, lat_window_reg});
    assign below_win = $signed({dlat_reg[31], dlat_reg})
                     < ($signed(33'd0) - $signed({3'b000, lat_window_reg}));
    assign skip      = window_passed_reg || above_win || below_win;

    always_comb
    begin
        case (uc.cond)
            npws_pkg::C_NEVER:       cond_hit = 1'b0;
            npws_pkg::C_NO_INPUT:    cond_hit = !in_xfer;
            npws_pkg::C_SKIP:        cond_hit = skip;
            npws_pkg::C_OUT_BLOCKED: cond_hit = out_blocked;
            default:                 cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? uc.tgt_true : uc.tgt_false;
    end

    // Shared multiplier.
    always_comb
    begin
        case (uc.mul_sel)
            npws_pkg::MUL_LON:
            begin
                mul_a = dlon_mag_reg;
                mul_b = 32'(lon_scale_reg);
            end
            npws_pkg::MUL_DLAT:
            begin
                mul_a = {1'b0, dlat_mag_reg};
                mul_b = dlat_mag_reg;
            end
            npws_pkg::MUL_SCL:
            begin
                mul_a = {1'b0, scaled_reg};
                mul_b = scaled_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // Round the scaled longitude difference to nearest, ties away from zero.
    assign rnd_w    = prod_reg[49:0] + npws_pkg::ROUND_HALF;
    assign scaled_w = rnd_w[49:16];

    assign sq2_w   = scaled_sat_reg ? npws_pkg::DIST_MAX : prod_reg[npws_pkg::DIST_W-1:0];
    assign sum_w   = {1'b0, acc_reg} + {1'b0, sq2_w};
    assign dist_w  = sum_w[63] ? npws_pkg::DIST_MAX : sum_w[npws_pkg::DIST_W-1:0];
    assign found_w = best_dist_reg < max_dist_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_lat_reg  <= npws_pkg::TARGET_LAT_RST;
            target_lon_reg  <= npws_pkg::TARGET_LON_RST;
            lon_scale_reg   <= npws_pkg::LON_SCALE_RST;
            lat_window_reg  <= npws_pkg::LAT_WINDOW_RST;
            max_dist_sq_reg <= npws_pkg::MAX_DIST_SQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npws_pkg::REG_TARGET_LAT:  target_lat_reg  <= cfg_data[npws_pkg::LAT_W-1:0];
                npws_pkg::REG_TARGET_LON:  target_lon_reg  <= cfg_data[npws_pkg::LON_W-1:0];
                npws_pkg::REG_LON_SCALE:   lon_scale_reg   <= cfg_data[npws_pkg::SCALE_W-1:0];
                npws_pkg::REG_LAT_WINDOW:  lat_window_reg  <= cfg_data[npws_pkg::WIN_W-1:0];
                npws_pkg::REG_MAX_DIST_SQ: max_dist_sq_reg <= cfg_data[npws_pkg::DIST_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= npws_pkg::S_ACCEPT;
            best_dist_reg     <= npws_pkg::MAX_DIST_SQ_RST;
            best_idx_reg      <= '0;
            window_passed_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (restart_in || emit)
            begin
                best_dist_reg     <= max_dist_sq_reg;
                best_idx_reg      <= '0;
                window_passed_reg <= 1'b0;
            end
            else
            begin
                if (uc.win_chk && !window_passed_reg && above_win)
                begin
                    window_passed_reg <= 1'b1;
                end
                if (uc.upd_best && (dist_w < best_dist_reg))
                begin
                    best_dist_reg <= dist_w;
                    best_idx_reg  <= idx_reg;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            last_reg     <= in_ch.last;
            idx_reg      <= in_ch.rec_index[IDX_W-1:0];
            dlat_reg     <= dlat_w;
            dlat_mag_reg <= dlat_mag_w;
            dlon_mag_reg <= dlon_mag_w;
        end
        if (uc.ld_prod)
        begin
            prod_reg <= mul_p;
        end
        if (uc.ld_scaled)
        begin
            scaled_reg     <= scaled_w[31:0];
            scaled_sat_reg <= scaled_w > npws_pkg::SQ_LIMIT;
        end
        if (uc.ld_acc)
        begin
            acc_reg <= prod_reg[npws_pkg::DIST_W-1:0];
        end
        if (emit)
        begin
            out_found_reg <= found_w;
            out_index_reg <= found_w ? IW'(best_idx_reg) : '0;
            out_dist_reg  <= best_dist_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.found      = out_found_reg;
    assign out_ch.best_index = out_index_reg;
    assign out_ch.best_dist  = out_dist_reg;

`ifndef SYNTHESIS
    // A distance update can only lower the best distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == npws_pkg::S_SUM) |=> (best_dist_reg <= $past(best_dist_reg)))
        else $error("best distance grew during an update");

    // A skipped record leaves the best distance alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((step_reg == npws_pkg::S_SCALE) && skip) |=> $stable(best_dist_reg))
        else $error("skipped record changed the best distance");

    // The window flag only clears when a search restarts.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(window_passed_reg) |-> $past(emit || restart_in))
        else $error("window flag cleared outside a restart");

    // A result is presented after emit, with a zero index when nothing was found.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_ch.valid && (out_ch.found || (out_ch.best_index == '0))))
        else $error("result missing or index set without a match");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import npws_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam longint LAT_LIM = 754974720;
    localparam longint LON_LIM = 1509949440;
    localparam int SETTLE = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS = 100;

    // Kinds of configuration chosen for a phase.
    localparam int CFG_RANDOM = 0;
    localparam int CFG_HIGH   = 1;
    localparam int CFG_LOW    = 2;

    typedef struct {
        logic                     first;
        logic                     last;
        logic signed [LAT_W-1:0]  lat;
        logic signed [LON_W-1:0]  lon;
        logic [INDEX_W-1:0]       idx;
    } record_t;

    typedef struct {
        logic                found;
        logic [INDEX_W-1:0]  best_index;
        logic [DIST_W-1:0]   best_dist;
    } nearest_t;

    typedef enum bit {ROW_REC, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        record_t               rec;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        bit                    typed;
        nearest_t              want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    npws_in_if  in_ch ();
    npws_out_if out_ch ();

    nearest_point_window_scan_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copy of the registers and of the search state.
    longint               tgt_lat;
    longint               tgt_lon;
    logic [SCALE_W-1:0]   scale;
    logic [WIN_W-1:0]     window;
    logic [DIST_W-1:0]    dist_limit;
    logic [DIST_W-1:0]    best_dist;
    logic [INDEX_W-1:0]   best_idx;
    bit                   passed;

    nearest_t   nearest_q[$];
    nearest_t   no_want;
    plan_row_t  plan[$];

    int  mismatches;
    int  records_sent;
    int  results_checked;
    int  found_count;
    int  tables_sent;
    int  stall_cycles;
    int  random_start;
    int  phase_end;
    int  phase;
    bit  calm;

    always #1 clk = ~clk;

    function automatic logic [63:0] magnitude(input longint v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        return m;
    endfunction

    function automatic logic [63:0] square_sat(input logic [63:0] m);
        if (m > 64'(SQ_LIMIT))
            return {1'b0, DIST_MAX};
        return m * m;
    endfunction

    function automatic void restart_search();
        best_dist = dist_limit;
        best_idx = '0;
        passed = 1'b0;
    endfunction

    // Advances the search by one record; returns 1 when the record closes a table.
    function automatic bit scan_record(input record_t r, output nearest_t res);
        longint dlat;
        logic [63:0] scaled;
        logic [63:0] rec_dist;
        if (r.first)
            restart_search();
        if (!passed)
        begin
            dlat = longint'(r.lat) - tgt_lat;
            if (dlat > longint'(window))
                passed = 1'b1;
            else if (dlat >= -longint'(window))
            begin
                scaled = (magnitude(longint'(r.lon) - tgt_lon) * 64'(scale) + 64'd32768) >> 16;
                rec_dist = square_sat(magnitude(dlat)) + square_sat(scaled);
                if (rec_dist > {1'b0, DIST_MAX})
                    rec_dist = {1'b0, DIST_MAX};
                if (rec_dist[DIST_W-1:0] < best_dist)
                begin
                    best_dist = rec_dist[DIST_W-1:0];
                    best_idx = r.idx;
                end
            end
        end
        res.found = best_dist < dist_limit;
        res.best_index = res.found ? best_idx : '0;
        res.best_dist = best_dist;
        if (!r.last)
            return 1'b0;
        restart_search();
        return 1'b1;
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint rand_signed(input longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    function automatic int idle_run();
        int n;
        n = 0;
        if (calm)
            return 0;
        while (n < 12 && $urandom_range(0, 99) < 35)
            n++;
        return n;
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit(input int mode);
        logic [63:0] span;
        if (mode == CFG_HIGH)
            return DIST_MAX;
        if (mode == CFG_LOW)
            return '0;
        span = 64'(window) * 64'(window) * 2 + 1;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DIST_MAX;
            2: return MAX_DIST_SQ_RST;
            3: return CFG_W'({$urandom, $urandom});
            default: return CFG_W'({$urandom, $urandom} % span);
        endcase
    endfunction

    function automatic void add_rec(input logic f, input logic l, input longint lat,
                                    input longint lon, input logic [INDEX_W-1:0] idx,
                                    input bit typed = 1'b0, input logic wf = 1'b0,
                                    input logic [INDEX_W-1:0] wi = '0,
                                    input logic [DIST_W-1:0] wd = '0);
        plan_row_t row;
        row.kind = ROW_REC;
        row.rec.first = f;
        row.rec.last = l;
        row.rec.lat = LAT_W'(lat);
        row.rec.lon = LON_W'(lon);
        row.rec.idx = idx;
        row.typed = typed;
        row.want.found = wf;
        row.want.best_index = wi;
        row.want.best_dist = wd;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        plan_row_t row;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed = 1'b0;
        plan.push_back(row);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_TARGET_LAT:  tgt_lat = $signed(val[LAT_W-1:0]);
            REG_TARGET_LON:  tgt_lon = $signed(val[LON_W-1:0]);
            REG_LON_SCALE:   scale = val[SCALE_W-1:0];
            REG_LAT_WINDOW:  window = val[WIN_W-1:0];
            REG_MAX_DIST_SQ: dist_limit = val[DIST_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_record(input record_t r, input bit typed, input nearest_t want);
        int gap;
        nearest_t res;
        gap = idle_run();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.first <= r.first;
        in_ch.last <= r.last;
        in_ch.rec_lat <= r.lat;
        in_ch.rec_lon <= r.lon;
        in_ch.rec_index <= r.idx;
        do
            @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        records_sent++;
        if (scan_record(r, res))
            nearest_q.push_back(typed ? want : res);
    endtask

    // Holds the sender off until every pending result has been checked and the
    // unit has had time to finish a record that produces no result.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input int mode);
        longint lat_t;
        longint lon_t;
        logic [CFG_W-1:0] scale_v;
        logic [CFG_W-1:0] win_v;
        case (mode)
            CFG_HIGH:
            begin
                lat_t = LAT_LIM;
                lon_t = LON_LIM;
                scale_v = CFG_W'(17'h1FFFF);
                win_v = CFG_W'(LAT_LIM);
            end
            CFG_LOW:
            begin
                lat_t = -LAT_LIM;
                lon_t = -LON_LIM;
                scale_v = '0;
                win_v = '0;
            end
            default:
            begin
                lat_t = rand_signed(LAT_LIM);
                lon_t = rand_signed(LON_LIM);
                if ($urandom_range(0, 5) == 0)
                    lat_t = $urandom_range(0, 1) ? LAT_LIM : -LAT_LIM;
                if ($urandom_range(0, 5) == 0)
                    lon_t = $urandom_range(0, 1) ? LON_LIM : -LON_LIM;
                case ($urandom_range(0, 5))
                    0: scale_v = '0;
                    1: scale_v = CFG_W'(LON_SCALE_RST);
                    2: scale_v = CFG_W'($urandom_range(65537, 131071));
                    default: scale_v = CFG_W'($urandom_range(0, 65536));
                endcase
                case ($urandom_range(0, 5))
                    0: win_v = '0;
                    1: win_v = CFG_W'(LAT_LIM);
                    2: win_v = CFG_W'(LAT_WINDOW_RST);
                    default: win_v = CFG_W'($urandom_range(0, 1 << $urandom_range(4, 28)));
                endcase
            end
        endcase
        write_reg(REG_TARGET_LAT, CFG_W'(lat_t));
        write_reg(REG_TARGET_LON, CFG_W'(lon_t));
        write_reg(REG_LON_SCALE, scale_v);
        write_reg(REG_LAT_WINDOW, win_v);
        write_reg(REG_MAX_DIST_SQ, pick_limit(mode));
    endtask

    // A table sorted by latitude that starts below the window and climbs past it.
    task automatic send_table();
        int n;
        longint cur;
        longint step_max;
        longint lon_spread;
        record_t r;
        logic [INDEX_W-1:0] base;
        bit mid_write;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 8);
        step_max = (3 * longint'(window)) / n + 2;
        cur = tgt_lat - longint'(window) - longint'(window) / 2 - $urandom_range(0, 3);
        lon_spread = ($urandom_range(0, 2) == 0) ? LON_LIM : longint'(1) << $urandom_range(0, 30);
        base = INDEX_W'($urandom);
        mid_write = (n > 1) && ($urandom_range(0, 11) == 0);
        for (int k = 0; k < n; k++)
        begin
            cur = cur + $urandom_range(0, 32'(step_max));
            r.first = (k == 0) && ($urandom_range(0, 7) != 0);
            r.last = (k == n - 1);
            // Now and then the previous coordinates are kept, giving a distance tie.
            if (k == 0 || $urandom_range(0, 5) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: r.lat = LAT_W'(clamp(tgt_lat - longint'(window), LAT_LIM));
                    1: r.lat = LAT_W'(clamp(tgt_lat + longint'(window), LAT_LIM));
                    default: r.lat = LAT_W'(clamp(cur, LAT_LIM));
                endcase
                r.lon = LON_W'(clamp(tgt_lon + rand_signed(lon_spread), LON_LIM));
            end
            r.idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom) : INDEX_W'(base + k);
            push_record(r, 1'b0, no_want);
            if (mid_write && k == n / 2 - 1)
            begin
                drain();
                write_reg(REG_MAX_DIST_SQ, pick_limit(CFG_RANDOM));
            end
        end
        tables_sent++;
    endtask

    task automatic send_noise();
        record_t r;
        r.first = $urandom_range(0, 3) == 0;
        r.last = $urandom_range(0, 5) == 0;
        r.lat = LAT_W'(rand_signed(LAT_LIM));
        r.lon = LON_W'(rand_signed(LON_LIM));
        r.idx = INDEX_W'($urandom);
        push_record(r, 1'b0, no_want);
    endtask

    always @(negedge clk)
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);

    always @(posedge clk)
    begin : check_result
        nearest_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (nearest_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: found %0b index %0d dist %0d",
                         $time, out_ch.found, out_ch.best_index, out_ch.best_dist);
                mismatches++;
            end
            else
            begin
                want = nearest_q.pop_front();
                results_checked++;
                if (want.found)
                    found_count++;
                if (out_ch.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, out_ch.found);
                    mismatches++;
                end
                if (out_ch.best_index !== want.best_index)
                begin
                    $display("%0t: best_index expected %0d actual %0d",
                             $time, want.best_index, out_ch.best_index);
                    mismatches++;
                end
                if (out_ch.best_dist !== want.best_dist)
                begin
                    $display("%0t: best_dist expected %0d actual %0d",
                             $time, want.best_dist, out_ch.best_dist);
                    mismatches++;
                end
            end
        end
    end

    // Counts cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, nearest_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.first = 1'b0;
        in_ch.last = 1'b0;
        in_ch.rec_lat = '0;
        in_ch.rec_lon = '0;
        in_ch.rec_index = '0;
        calm = 1'b0;
        records_sent = 0;
        tables_sent = 0;
        tgt_lat = $signed(TARGET_LAT_RST);
        tgt_lon = $signed(TARGET_LON_RST);
        scale = LON_SCALE_RST;
        window = LAT_WINDOW_RST;
        dist_limit = MAX_DIST_SQ_RST;
        restart_search();

        // Target at the origin with the settings from reset.
        add_rec(1, 1, 0, 0, 5, 1'b1, 1'b1, 5, 0);
        add_rec(1, 1, LAT_LIM, 0, 1, 1'b1, 1'b0, 0, MAX_DIST_SQ_RST);
        add_rec(1, 1, -LAT_LIM, -LON_LIM, 2, 1'b1, 1'b0, 0, MAX_DIST_SQ_RST);
        // Below the window, both edges, a far record, then a record past the
        // window so that the close record after it is ignored.
        add_rec(1, 0, -4194305, 0, 3);
        add_rec(0, 0, -4194304, 0, 4);
        add_rec(0, 0, 4194304, LON_LIM, 6);
        add_rec(0, 0, 4194305, 0, 7);
        add_rec(0, 1, 0, 0, 20'hFFFFF, 1'b1, 1'b0, 0, MAX_DIST_SQ_RST);
        // No first mark: the previous last has rearmed the search.
        add_rec(0, 1, 0, 0, 8, 1'b1, 1'b1, 8, 0);
        add_cfg(REG_MAX_DIST_SQ, DIST_MAX);
        add_rec(1, 0, -4194305, 0, 9);
        add_rec(0, 1, -4194304, 0, 10, 1'b1, 1'b1, 10, 63'd17592186044416);
        // Equal distances: the earlier record stays the best.
        add_rec(1, 0, 4194304, 0, 11);
        add_rec(0, 0, 4194304, 0, 12);
        add_rec(0, 1, 4194305, 0, 13, 1'b1, 1'b1, 11, 63'd17592186044416);
        // Extreme target, widest window and a scale above one saturate the longitude squares.
        add_cfg(REG_TARGET_LAT, CFG_W'(-LAT_LIM));
        add_cfg(REG_TARGET_LON, CFG_W'(LON_LIM));
        add_cfg(REG_LON_SCALE, CFG_W'(17'h1FFFF));
        add_cfg(REG_LAT_WINDOW, CFG_W'(LAT_LIM));
        add_rec(1, 0, 0, -LON_LIM, 20'hFFFFF);
        add_rec(0, 1, 0, 0, 14);
        // The limit changes in the middle of a search.
        add_cfg(REG_TARGET_LAT, '0);
        add_cfg(REG_TARGET_LON, '0);
        add_cfg(REG_LAT_WINDOW, '0);
        add_cfg(REG_LON_SCALE, '0);
        add_rec(1, 0, 0, 100, 15);
        add_cfg(REG_MAX_DIST_SQ, '0);
        add_rec(0, 1, 0, 0, 16, 1'b1, 1'b0, 0, 0);
        // A write to an unused index changes nothing.
        add_cfg(REG_SPARE, DIST_MAX);
        add_rec(1, 1, 0, 0, 19, 1'b1, 1'b0, 0, 0);
        // Half-way rounding of the scaled longitude.
        add_cfg(REG_MAX_DIST_SQ, DIST_MAX);
        add_cfg(REG_LON_SCALE, CFG_W'(32768));
        add_cfg(REG_LAT_WINDOW, CFG_W'(LAT_WINDOW_RST));
        add_rec(1, 1, 0, -1, 20'hFFFFF);
        add_rec(1, 1, 0, 3, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                push_record(plan[i].rec, plan[i].typed, plan[i].want);
        end

        random_start = records_sent;
        for (phase = 0; records_sent - random_start < RANDOM_ITEMS; phase++)
        begin
            drain();
            calm = (phase == 3);
            configure(phase == 0 ? CFG_HIGH : (phase == 1 ? CFG_LOW : CFG_RANDOM));
            phase_end = records_sent + PHASE_ITEMS;
            while (records_sent < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) send_noise();
                else
                    send_table();
            end
        end
        calm = 1'b0;

        drain();
        $display("Summary: %0d records (%0d random tables) over %0d register settings.",
                 records_sent, tables_sent, phase);
        $display("Summary: %0d results compared, %0d with a point found, %0d mismatches.",
                 results_checked, found_count, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
